// ===== sv/khs_pkg.sv =====
// khs_pkg: shared types and key codes for the keystroke hold stretcher.
// No dependencies; imported by the interfaces, the key decoder and the top level.
`default_nettype none

package khs_pkg;

  localparam int BUTTON_SLOTS = 8;
  localparam int CNT_W        = 8;
  localparam int CODE_W       = 16;

  typedef logic [BUTTON_SLOTS-1:0] button_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [CODE_W-1:0]       code_t;

  localparam count_t HOLD_RESET = 8'd20;

  // action codes
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // scan codes
  localparam code_t SC_UP     = 16'h0001;
  localparam code_t SC_DOWN   = 16'h0002;
  localparam code_t SC_RIGHT  = 16'h0003;
  localparam code_t SC_LEFT   = 16'h0004;
  localparam code_t SC_ESCAPE = 16'h0017;

  // characters
  localparam code_t CH_CR   = 16'h000D;
  localparam code_t CH_BS   = 16'h0008;
  localparam code_t CH_Z_LO = 16'h007A;
  localparam code_t CH_Z_UP = 16'h005A;
  localparam code_t CH_X_LO = 16'h0078;
  localparam code_t CH_X_UP = 16'h0058;

  // button bit positions
  localparam int BIT_A      = 0;
  localparam int BIT_B      = 1;
  localparam int BIT_SELECT = 2;
  localparam int BIT_START  = 3;
  localparam int BIT_UP     = 4;
  localparam int BIT_DOWN   = 5;
  localparam int BIT_LEFT   = 6;
  localparam int BIT_RIGHT  = 7;

  typedef struct packed {
    logic    escape;  // escape key, takes priority over everything
    button_t mask;    // one-hot button to recharge, zero if unmapped
  } key_decode_t;

endpackage

`default_nettype wire

// ===== sv/khs_in_if.sv =====
// khs_in_if: valid/ready channel carrying one keystroke or frame tick.
// Depends on khs_pkg for the code type.
`default_nettype none

interface khs_in_if;
  import khs_pkg::*;

  logic  valid;
  logic  ready;
  logic  action;
  code_t scan_code;
  code_t unicode_char;

  modport source (output valid, output action, output scan_code, output unicode_char,
                  input ready);
  modport sink   (input valid, input action, input scan_code, input unicode_char,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/khs_out_if.sv =====
// khs_out_if: valid/ready channel carrying one frame's button report.
// Depends on khs_pkg for the button type.
`default_nettype none

interface khs_out_if;
  import khs_pkg::*;

  logic    valid;
  logic    ready;
  button_t current_buttons;
  button_t pressed_buttons;
  logic    escape_held;

  modport source (output valid, output current_buttons, output pressed_buttons,
                  output escape_held, input ready);
  modport sink   (input valid, input current_buttons, input pressed_buttons,
                  input escape_held, output ready);
endinterface

`default_nettype wire

// ===== sv/keystroke_hold_stretcher.sv =====
// keystroke_hold_stretcher: one transaction per cycle; a tick's report is loaded
// into the result register when the tick is accepted, keystrokes produce no
// report. Throughput is one transaction per cycle, set by the single
// result register: input is taken whenever that register is empty or draining.
// Synchronous active-low reset clears counters, previous buttons and valid,
// and loads hold_length with 20. Depends on khs_pkg, khs_in_if, khs_out_if,
// khs_key_decode.
`default_nettype none

module keystroke_hold_stretcher (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire khs_pkg::count_t cfg_wdata,
  khs_in_if.sink               in_ch,
  khs_out_if.source            out_ch
);
  import khs_pkg::*;

  // ---------------------------------------------------------------
  // State
  // ---------------------------------------------------------------
  count_t  hold_len_r;
  count_t  cnt_r   [BUTTON_SLOTS];
  count_t  cnt_nxt [BUTTON_SLOTS];
  count_t  esc_cnt_r, esc_cnt_nxt;
  button_t prev_r, prev_nxt;

  // result register
  logic    out_valid_r, out_valid_nxt;
  button_t out_cur_r, out_cur_nxt;
  button_t out_prs_r, out_prs_nxt;
  logic    out_esc_r, out_esc_nxt;

  key_decode_t dec;
  button_t     cur;
  logic        in_acc;
  logic        out_acc;

  khs_key_decode u_dec (
    .scan_code    (in_ch.scan_code),
    .unicode_char (in_ch.unicode_char),
    .dec          (dec)
  );

  // Take a transaction whenever the result register is free or being drained
  // this cycle; keystrokes ride the same condition so ordering stays simple.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_valid_r && out_ch.ready;

  // buttons held this frame: any nonzero counter
  always_comb begin
    for (int i = 0; i < BUTTON_SLOTS; i++) begin
      cur[i] = (cnt_r[i] != '0);
    end
  end

  // ---------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < BUTTON_SLOTS; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    esc_cnt_nxt   = esc_cnt_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && !out_acc;
    out_cur_nxt   = out_cur_r;
    out_prs_nxt   = out_prs_r;
    out_esc_nxt   = out_esc_r;

    if (in_acc) begin
      if (in_ch.action == ACT_KEY) begin
        // keystroke: recharge escape, or the decoded button
        if (dec.escape) begin
          esc_cnt_nxt = hold_len_r;
        end else begin
          for (int i = 0; i < BUTTON_SLOTS; i++) begin
            if (dec.mask[i]) cnt_nxt[i] = hold_len_r;
          end
        end
      end else begin
        // frame tick: report, then count down the live counters
        for (int i = 0; i < BUTTON_SLOTS; i++) begin
          if (cur[i]) cnt_nxt[i] = cnt_r[i] - count_t'(1);
        end
        if (esc_cnt_r != '0) esc_cnt_nxt = esc_cnt_r - count_t'(1);
        prev_nxt      = cur;
        out_valid_nxt = 1'b1;
        out_cur_nxt   = cur;
        out_prs_nxt   = cur & ~prev_r;
        out_esc_nxt   = (esc_cnt_r != '0);
      end
    end
  end

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_len_r  <= HOLD_RESET;
      for (int i = 0; i < BUTTON_SLOTS; i++) begin
        cnt_r[i] <= '0;
      end
      esc_cnt_r   <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) hold_len_r <= cfg_wdata;
      for (int i = 0; i < BUTTON_SLOTS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      esc_cnt_r   <= esc_cnt_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    out_cur_r <= out_cur_nxt;
    out_prs_r <= out_prs_nxt;
    out_esc_r <= out_esc_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.current_buttons = out_cur_r;
  assign out_ch.pressed_buttons = out_prs_r;
  assign out_ch.escape_held     = out_esc_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // a tick always leaves a report in the result register
  a_tick_reports: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.action == ACT_TICK |=> out_valid_r)
    else $error("tick accepted without a report");

  // a keystroke never creates a report
  a_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.action == ACT_KEY && !out_valid_r |=> !out_valid_r)
    else $error("keystroke produced a report");

  // pending report matches the frame history
  a_prev_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> prev_r == out_cur_r)
    else $error("previous buttons out of step with report");

  // new presses are a subset of held buttons
  a_pressed_sub: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_prs_r & ~out_cur_r) == '0)
    else $error("pressed bit without held bit");

  // decoder picks at most one button
  a_dec_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(dec.mask))
    else $error("key decoded to several buttons");

endmodule

`default_nettype wire

// ===== sv/khs_key_decode.sv =====
// khs_key_decode: maps a scan code / character pair to escape or a button.
// Depends on khs_pkg.
`default_nettype none

module khs_key_decode (
  input  wire khs_pkg::code_t  scan_code,
  input  wire khs_pkg::code_t  unicode_char,
  output khs_pkg::key_decode_t dec
);
  import khs_pkg::*;

  always_comb begin
    dec.escape = (scan_code == SC_ESCAPE);
    dec.mask   = '0;
    // first match wins: scan codes, then characters
    if (scan_code == SC_RIGHT) begin
      dec.mask[BIT_RIGHT] = 1'b1;
    end else if (scan_code == SC_LEFT) begin
      dec.mask[BIT_LEFT] = 1'b1;
    end else if (scan_code == SC_DOWN) begin
      dec.mask[BIT_DOWN] = 1'b1;
    end else if (scan_code == SC_UP) begin
      dec.mask[BIT_UP] = 1'b1;
    end else if (unicode_char == CH_CR) begin
      dec.mask[BIT_START] = 1'b1;
    end else if (unicode_char == CH_BS) begin
      dec.mask[BIT_SELECT] = 1'b1;
    end else if (unicode_char == CH_Z_LO || unicode_char == CH_Z_UP) begin
      dec.mask[BIT_B] = 1'b1;
    end else if (unicode_char == CH_X_LO || unicode_char == CH_X_UP) begin
      dec.mask[BIT_A] = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== dv/khs_report_check.sv =====
`timescale 1ns / 1ps
// khs_report_check: watches both channels of the hold stretcher, predicts every
// frame report and compares it field by field. Depends on khs_pkg, khs_in_if, khs_out_if.

module khs_report_check (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  khs_pkg::count_t cfg_wdata,
  khs_in_if               in_ch,
  khs_out_if              out_ch,
  output int              mismatches,
  output int              reports_waiting,
  output int              reports_checked
);
  import khs_pkg::*;

  typedef struct packed {
    button_t current;
    button_t pressed;
    logic    escape;
  } frame_report_t;

  frame_report_t expected_reports[$];

  count_t  hold_len;
  count_t  hold_cnt [BUTTON_SLOTS];
  count_t  esc_cnt;
  button_t prev_buttons;

  initial begin
    mismatches      = 0;
    reports_waiting = 0;
    reports_checked = 0;
  end

  // first match wins: arrows by scan code, then characters
  function automatic int key_bit(code_t sc, code_t ch);
    if (sc == SC_RIGHT) return BIT_RIGHT;
    if (sc == SC_LEFT) return BIT_LEFT;
    if (sc == SC_DOWN) return BIT_DOWN;
    if (sc == SC_UP) return BIT_UP;
    if (ch == CH_CR) return BIT_START;
    if (ch == CH_BS) return BIT_SELECT;
    if (ch == CH_Z_LO || ch == CH_Z_UP) return BIT_B;
    if (ch == CH_X_LO || ch == CH_X_UP) return BIT_A;
    return -1;
  endfunction

  task automatic absorb_transaction(logic act, code_t sc, code_t ch);
    int            b;
    frame_report_t rep;
    if (act == ACT_KEY) begin
      if (sc == SC_ESCAPE) begin
        esc_cnt = hold_len;
      end else begin
        b = key_bit(sc, ch);
        if (b >= 0) hold_cnt[b] = hold_len;
      end
    end else begin
      rep.current = '0;
      for (int i = 0; i < BUTTON_SLOTS; i++) begin
        if (hold_cnt[i] != '0) begin
          rep.current[i] = 1'b1;
          hold_cnt[i]    = hold_cnt[i] - count_t'(1);
        end
      end
      rep.pressed = rep.current & ~prev_buttons;
      rep.escape  = (esc_cnt != '0);
      if (esc_cnt != '0) esc_cnt = esc_cnt - count_t'(1);
      prev_buttons = rep.current;
      expected_reports.push_back(rep);
    end
  endtask

  task automatic report_mismatch(string what);
    mismatches++;
    // keep the log short on a badly broken run
    if (mismatches <= 50) $display("%0t khs_report_check: %s", $time, what);
  endtask

  task automatic compare_report();
    frame_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("report with none expected, current %02h",
                                out_ch.current_buttons));
      return;
    end
    want = expected_reports.pop_front();
    reports_checked++;
    if (out_ch.current_buttons !== want.current)
      report_mismatch($sformatf("report %0d current_buttons %02h, expected %02h",
                                reports_checked, out_ch.current_buttons, want.current));
    if (out_ch.pressed_buttons !== want.pressed)
      report_mismatch($sformatf("report %0d pressed_buttons %02h, expected %02h",
                                reports_checked, out_ch.pressed_buttons, want.pressed));
    if (out_ch.escape_held !== want.escape)
      report_mismatch($sformatf("report %0d escape_held %b, expected %b",
                                reports_checked, out_ch.escape_held, want.escape));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_len     = HOLD_RESET;
      esc_cnt      = '0;
      prev_buttons = '0;
      for (int i = 0; i < BUTTON_SLOTS; i++) hold_cnt[i] = '0;
      expected_reports.delete();
    end else begin
      if (cfg_we === 1'b1) hold_len = cfg_wdata;
      // a report never leaves in the cycle its tick is taken, so compare first
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) compare_report();
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        absorb_transaction(in_ch.action, in_ch.scan_code, in_ch.unicode_char);
    end
    reports_waiting = expected_reports.size();
  end

endmodule

// ===== dv/keystroke_hold_stretcher_tb.sv =====
`timescale 1ns / 1ps
// keystroke_hold_stretcher_tb: top of the bench; drives keystrokes, ticks and the
// hold length, and gives the verdict. Depends on khs_pkg, both channel interfaces,
// khs_report_check and the keystroke_hold_stretcher RTL.

module keystroke_hold_stretcher_tb;
  import khs_pkg::*;

  // no transaction for this many cycles means the block is stuck
  localparam int STALL_LIMIT     = 5000;
  // long receiver hold-off, well under STALL_LIMIT
  localparam int HOLD_OFF_CYCLES = 300;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  count_t cfg_wdata;

  khs_in_if  in_ch ();
  khs_out_if out_ch ();

  int mismatches;
  int reports_waiting;
  int reports_checked;

  int keys_sent       = 0;
  int ticks_sent      = 0;
  int settings_used   = 0;
  int burst_left      = 0;
  int stall_cycles    = 0;
  int hold_off_asked  = 0;
  int hold_off_served = 0;

  keystroke_hold_stretcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  khs_report_check report_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatches      (mismatches),
    .reports_waiting (reports_waiting),
    .reports_checked (reports_checked)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("keystroke_hold_stretcher_tb: no transaction for %0d cycles", STALL_LIMIT);
        $display("keystroke_hold_stretcher_tb: done, errors");
        $finish;
      end
    end
  end

  // Receiver: ready follows a pattern that is redrawn at random intervals.
  // A hold-off request from the stimulus drops ready for a long hold-off.
  initial begin
    int mode;
    int mode_left;
    int phase;
    mode         = 0;
    mode_left    = 0;
    phase        = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_asked > hold_off_served) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_served++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        phase++;
        case (mode)
          0:       out_ch.ready = 1'b1;                      // no stalls at all
          1:       out_ch.ready = 1'($urandom_range(0, 1));
          2:       out_ch.ready = ($urandom_range(0, 3) == 0); // mostly stalled
          default: out_ch.ready = (phase % 3 != 0);          // fixed rhythm
        endcase
      end
    end
  end

  // Offer one transaction and wait until it is taken. Items go out in bursts;
  // between bursts valid drops for a random gap (sometimes none).
  task automatic send_transaction(logic act, code_t sc, code_t ch);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 20);
      endcase
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.action       = act;
    in_ch.scan_code    = sc;
    in_ch.unicode_char = ch;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (act == ACT_TICK) ticks_sent++;
    else keys_sent++;
  endtask

  task automatic send_key(code_t sc, code_t ch);
    send_transaction(ACT_KEY, sc, ch);
  endtask

  // tick payload is don't-care, so it is random
  task automatic send_tick();
    send_transaction(ACT_TICK, code_t'($urandom_range(0, 65535)),
                     code_t'($urandom_range(0, 65535)));
  endtask

  // Stop offering and wait for every expected report; a keystroke still in
  // flight makes no report, so the wait goes on past the last report.
  task automatic drain_reports();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (reports_waiting != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_hold_length(count_t value);
    drain_reports();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // Mostly ticks and mapped keys with random leftovers in the other field;
  // the rest is noise. Only ticks and mapped keys count toward the phase.
  task automatic send_random_item(inout int useful);
    int    pick;
    code_t sc;
    code_t ch;
    pick = $urandom_range(0, 99);
    sc   = code_t'($urandom_range(0, 65535));
    ch   = code_t'($urandom_range(0, 65535));
    if (pick < 45) begin
      send_tick();
      useful++;
    end else if (pick < 88) begin
      // characters use a zero scan code or one above every mapped code
      if (sc < 16'h0018) sc = '0;
      case ($urandom_range(0, 10))
        0:       sc = SC_ESCAPE;
        1:       sc = SC_UP;
        2:       sc = SC_DOWN;
        3:       sc = SC_RIGHT;
        4:       sc = SC_LEFT;
        5:       ch = CH_CR;
        6:       ch = CH_BS;
        7:       ch = CH_Z_LO;
        8:       ch = CH_Z_UP;
        9:       ch = CH_X_LO;
        default: ch = CH_X_UP;
      endcase
      send_key(sc, ch);
      useful++;
    end else begin
      if (pick < 94) sc = '0;
      send_key(sc, ch);
    end
    // now and then let every report come home mid-phase
    if ($urandom_range(0, 49) == 0) drain_reports();
  endtask

  task automatic random_phase(int count);
    int useful;
    useful = 0;
    while (useful < count) send_random_item(useful);
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_KEY;
    in_ch.scan_code    = '0;
    in_ch.unicode_char = '0;
    cfg_we             = 1'b0;
    cfg_wdata          = HOLD_RESET;
    rst_n              = 1'b0;
    repeat (7) @(negedge clk);
    rst_n         = 1'b1;
    settings_used = 1;

    // Directed, reset hold length: every key once, then key priority.
    send_tick();                        // nothing held yet
    send_key('0, CH_X_LO);
    send_tick();
    send_key('0, CH_Z_LO);
    send_key('0, CH_CR);
    send_key('0, CH_BS);
    send_tick();
    send_key(SC_UP, '0);
    send_key(SC_DOWN, '0);
    send_key(SC_LEFT, '0);
    send_key(SC_RIGHT, '0);
    send_tick();
    send_key(SC_ESCAPE, CH_X_LO);       // escape wins over the character
    send_tick();
    send_key(SC_RIGHT, CH_CR);          // scan code wins over the character
    send_key(SC_UP, CH_Z_UP);
    send_key('0, 16'hFFFF);             // unmapped, ignored
    send_key(16'hFFFF, '0);             // unmapped, ignored
    send_key('0, CH_Z_UP);
    send_key('0, CH_X_UP);
    send_tick();
    send_tick();

    // Shortest hold: buttons drop after one frame and press again.
    set_hold_length(8'd1);
    send_key('0, CH_X_UP);
    send_tick();
    send_tick();
    send_key(SC_ESCAPE, '0);
    send_tick();
    send_tick();
    random_phase(90);

    set_hold_length(8'd255);
    random_phase(90);

    // Zero hold: a recharge loads zero and shows nothing.
    set_hold_length(8'd0);
    send_key('0, CH_X_LO);
    send_key(SC_ESCAPE, '0);
    send_tick();
    random_phase(40);

    // Receiver holds off long while the sender keeps offering, so the result
    // register fills and the input stalls.
    set_hold_length(8'd3);
    hold_off_asked++;
    repeat (12) begin
      send_tick();
      send_key(SC_LEFT, '0);
    end
    random_phase(80);

    set_hold_length(count_t'($urandom_range(2, 8)));
    random_phase(90);
    set_hold_length(count_t'($urandom_range(2, 8)));
    random_phase(90);
    set_hold_length(count_t'($urandom_range(1, 255)));
    random_phase(60);
    set_hold_length(HOLD_RESET);
    random_phase(20);

    drain_reports();
    repeat (4) @(negedge clk);

    $display("keystroke_hold_stretcher_tb: run covered %0d keystrokes and %0d ticks, %0d reports",
             keys_sent, ticks_sent, reports_checked);
    $display("keystroke_hold_stretcher_tb: %0d hold lengths incl. 0, 1 and 255, %0d long hold-off",
             settings_used, hold_off_served);
    if (mismatches == 0 && reports_waiting == 0) begin
      $display("keystroke_hold_stretcher_tb: done, clean");
    end else begin
      $display("keystroke_hold_stretcher_tb: done, errors");
    end
    $finish;
  end

endmodule
